@@ design/tcce_pkg.sv @@
// Shared types and constants for the text console cursor engine.
// Used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    localparam int COL_W  = 9;
    localparam int ROW_W  = 8;
    localparam int CFG_W  = 10;
    localparam int ROWS_W = 9;
    localparam int CELL_SHIFT = 3;
    localparam int PX_W = COL_W + CELL_SHIFT;
    localparam int PY_W = ROW_W + CELL_SHIFT;

    localparam logic [CFG_W-1:0]  COLUMNS_RESET = 10'd80;
    localparam logic [ROWS_W-1:0] ROWS_RESET    = 9'd60;
    localparam logic [CFG_W-1:0]  COLUMNS_MAX   = 10'd512;
    localparam logic [ROWS_W-1:0] ROWS_MAX      = 9'd256;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic OP_GLYPH = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_FF = 8'd12;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] GLYPH_SPACE      = 8'h20;
    localparam logic [7:0] GLYPH_UNDERSCORE = 8'h5F;

    typedef struct packed {
        logic erase;
        logic draw;
        logic clear;
        logic cursor;
    } cmd_set_t;

    typedef struct packed {
        cmd_set_t         cmds;
        logic [COL_W-1:0] old_col;
        logic [ROW_W-1:0] old_row;
        logic [COL_W-1:0] new_col;
        logic [ROW_W-1:0] new_row;
        logic [7:0]       ch;
        logic [7:0]       cursor_glyph;
    } job_t;

endpackage

`default_nettype wire

@@ design/tcce_front.sv @@
// Front end: holds the screen size registers, the cursor and the blink phase,
// accepts input items and turns each into a job of up to four draw commands.
// Depends on tcce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcce_front
    import tcce_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                kind,
    input  wire logic [7:0]          ch,
    input  wire logic                first_of_write,
    input  wire logic                last_of_write,
    input  wire logic                q_full,
    output logic                     q_push,
    output job_t                     q_job
);

    logic [CFG_W-1:0]  columns_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              blink_reg;
    logic [CFG_W-1:0]  eff_cols;
    logic [ROWS_W-1:0] eff_rows;
    logic [CFG_W-1:0]  c;
    logic [ROWS_W-1:0] r;
    logic              accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (columns_reg == '0)
            eff_cols = CFG_W'(1);
        else if (columns_reg > COLUMNS_MAX)
            eff_cols = COLUMNS_MAX;
        else
            eff_cols = columns_reg;

        if (rows_reg == '0)
            eff_rows = ROWS_W'(1);
        else if (rows_reg > ROWS_MAX)
            eff_rows = ROWS_MAX;
        else
            eff_rows = rows_reg;

        q_job              = '0;
        q_job.old_col      = col_reg;
        q_job.old_row      = row_reg;
        q_job.ch           = ch;
        q_job.cursor_glyph = GLYPH_UNDERSCORE;
        c = {1'b0, col_reg};
        r = {1'b0, row_reg};

        if (kind == KIND_TICK)
        begin
            q_job.cmds.cursor  = 1'b1;
            q_job.cursor_glyph = blink_reg ? GLYPH_SPACE : GLYPH_UNDERSCORE;
        end
        else
        begin
            q_job.cmds.erase  = first_of_write;
            q_job.cmds.cursor = last_of_write;
            case (ch)
                CH_CR, CH_LF:
                begin
                    c = '0;
                    r = r + ROWS_W'(1);
                end
                CH_FF:
                begin
                    c = '0;
                    r = '0;
                    q_job.cmds.clear = 1'b1;
                end
                CH_BS:
                begin
                    if (col_reg == '0)
                    begin
                        // Wrap to the end of the previous row; the origin stays put.
                        if (row_reg != '0)
                        begin
                            c = eff_cols - CFG_W'(1);
                            r = r - ROWS_W'(1);
                        end
                    end
                    else
                    begin
                        c = c - CFG_W'(1);
                    end
                end
                default:
                begin
                    q_job.cmds.draw = 1'b1;
                    c = c + CFG_W'(1);
                end
            endcase

            if (c >= eff_cols)
            begin
                c = '0;
                r = r + ROWS_W'(1);
            end
            if (r >= eff_rows)
            begin
                c = '0;
                r = '0;
                q_job.cmds.clear = 1'b1;
            end
        end

        q_job.new_col = c[COL_W-1:0];
        q_job.new_row = r[ROW_W-1:0];
        col_next = (kind == KIND_TICK) ? col_reg : c[COL_W-1:0];
        row_next = (kind == KIND_TICK) ? row_reg : r[ROW_W-1:0];
        q_push   = accept && (q_job.cmds != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            blink_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COLUMNS: columns_reg <= cfg_data;
                    CFG_ROWS:    rows_reg    <= cfg_data[ROWS_W-1:0];
                    default:     columns_reg <= columns_reg;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (kind == KIND_TICK)
                    blink_reg <= !blink_reg;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/tcce_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on tcce_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module tcce_queue
    import tcce_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ design/tcce_back.sv @@
// Back end: takes jobs from the queue and issues their draw commands one per
// cycle while out_ready allows, through an output register. Depends on tcce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcce_back
    import tcce_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire job_t             q_job,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  op,
    output logic [PX_W-1:0]       pixel_x,
    output logic [PY_W-1:0]       pixel_y,
    output logic [7:0]            glyph,
    output logic                  last
);

    job_t             job_reg;
    cmd_set_t         pend_reg, pend_next, pend_after;
    logic             out_valid_reg, out_valid_next;
    logic             op_reg, op_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [7:0]       glyph_reg, glyph_next;
    logic             last_reg, last_next;
    logic             emit;
    logic             load;

    always_comb
    begin
        emit       = (pend_reg != '0) && (!out_valid_reg || out_ready);
        pend_after = pend_reg;
        op_next    = OP_GLYPH;
        col_next   = '0;
        row_next   = '0;
        glyph_next = '0;

        if (pend_reg.erase)
        begin
            pend_after.erase = 1'b0;
            col_next   = job_reg.old_col;
            row_next   = job_reg.old_row;
            glyph_next = GLYPH_SPACE;
        end
        else if (pend_reg.draw)
        begin
            pend_after.draw = 1'b0;
            col_next   = job_reg.old_col;
            row_next   = job_reg.old_row;
            glyph_next = job_reg.ch;
        end
        else if (pend_reg.clear)
        begin
            pend_after.clear = 1'b0;
            op_next = OP_CLEAR;
        end
        else
        begin
            pend_after.cursor = 1'b0;
            col_next   = job_reg.new_col;
            row_next   = job_reg.new_row;
            glyph_next = job_reg.cursor_glyph;
        end

        last_next = (pend_after == '0);
        load      = q_valid && ((pend_reg == '0) || (emit && last_next));
        q_pop     = load;

        if (load)
            pend_next = q_job.cmds;
        else if (emit)
            pend_next = pend_after;
        else
            pend_next = pend_reg;

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= q_job;
        if (emit)
        begin
            op_reg    <= op_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            glyph_reg <= glyph_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign op        = op_reg;
    assign pixel_x   = {col_reg, CELL_SHIFT'(0)};
    assign pixel_y   = {row_reg, CELL_SHIFT'(0)};
    assign glyph     = glyph_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

@@ design/text_console_cursor_engine.sv @@
// Text console cursor engine top level: front end, job queue and back end.
// Each item passes through a queue entry, the back end pending set and the output register.
// The back end issues one command per cycle while out_ready allows, so the
// commands of an item (one to four) go out back to back; items with none are not queued.
// The front end takes an item every cycle while the job queue has room.
// Reset: cursor at the origin, blink phase shows underscore next, 80 columns, 60 rows.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic [7:0]         ch,
    input  wire logic               first_of_write,
    input  wire logic               last_of_write,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    op,
    output logic [PX_W-1:0]         pixel_x,
    output logic [PY_W-1:0]         pixel_y,
    output logic [7:0]              glyph,
    output logic                    last
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    job_t push_job;
    job_t head_job;

    tcce_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .ch             (ch),
        .first_of_write (first_of_write),
        .last_of_write  (last_of_write),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    tcce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    tcce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .op        (op),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .glyph     (glyph),
        .last      (last)
    );

endmodule

`default_nettype wire

@@ dv/text_console_cursor_engine_tb.sv @@
// Self-checking testbench for the text console cursor engine.
// Depends on tcce_pkg and text_console_cursor_engine from the design folder.
`timescale 1ns / 1ps

import tcce_pkg::*;

typedef struct packed {
    logic            op;
    logic [PX_W-1:0] pixel_x;
    logic [PY_W-1:0] pixel_y;
    logic [7:0]      glyph;
    logic            last;
} draw_cmd_t;

class console_cmd_board;
    logic [CFG_W-1:0]  cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic              blink;
    draw_cmd_t         expected_cmds[$];
    int                mismatches;

    function new();
        cols_reg   = COLUMNS_RESET;
        rows_reg   = ROWS_RESET;
        cur_col    = '0;
        cur_row    = '0;
        blink      = 1'b0;
        mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] data);
        if (idx == CFG_COLUMNS)
        begin
            cols_reg = data;
        end
        else
        begin
            rows_reg = data[ROWS_W-1:0];
        end
    endfunction

    function void push_cmd(logic o, int col, int row, logic [7:0] g);
        draw_cmd_t cmd;
        cmd = '0;
        cmd.op = o;
        if (o == OP_GLYPH)
        begin
            cmd.pixel_x = PX_W'(col << CELL_SHIFT);
            cmd.pixel_y = PY_W'(row << CELL_SHIFT);
            cmd.glyph   = g;
        end
        expected_cmds.push_back(cmd);
    endfunction

    function void note_request(logic k, logic [7:0] c, logic f, logic l);
        int        eff_cols;
        int        eff_rows;
        int        col;
        int        row;
        int        base;
        draw_cmd_t tail;
        eff_cols = (cols_reg == '0) ? 1 :
                   ((cols_reg > COLUMNS_MAX) ? int'(COLUMNS_MAX) : int'(cols_reg));
        eff_rows = (rows_reg == '0) ? 1 :
                   ((rows_reg > ROWS_MAX) ? int'(ROWS_MAX) : int'(rows_reg));
        base = expected_cmds.size();
        if (k == KIND_TICK)
        begin
            push_cmd(OP_GLYPH, cur_col, cur_row, blink ? GLYPH_SPACE : GLYPH_UNDERSCORE);
            blink = ~blink;
        end
        else
        begin
            col = cur_col;
            row = cur_row;
            if (f)
            begin
                push_cmd(OP_GLYPH, cur_col, cur_row, GLYPH_SPACE);
            end
            if (c == CH_CR || c == CH_LF)
            begin
                col = 0;
                row++;
            end
            else if (c == CH_FF)
            begin
                col = 0;
                row = 0;
                push_cmd(OP_CLEAR, 0, 0, 8'h00);
            end
            else if (c == CH_BS)
            begin
                if (!(col == 0 && row == 0))
                begin
                    col--;
                end
            end
            else
            begin
                push_cmd(OP_GLYPH, col, row, c);
                col++;
            end
            if (col < 0)
            begin
                col = eff_cols - 1;
                row--;
            end
            if (col >= eff_cols)
            begin
                col = 0;
                row++;
            end
            if (row < 0)
            begin
                row = 0;
            end
            if (row >= eff_rows)
            begin
                col = 0;
                row = 0;
                push_cmd(OP_CLEAR, 0, 0, 8'h00);
            end
            cur_col = COL_W'(col);
            cur_row = ROW_W'(row);
            if (l)
            begin
                push_cmd(OP_GLYPH, cur_col, cur_row, GLYPH_UNDERSCORE);
            end
        end
        if (expected_cmds.size() > base)
        begin
            tail = expected_cmds.pop_back();
            tail.last = 1'b1;
            expected_cmds.push_back(tail);
        end
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            mismatches++;
        end
    endfunction

    function void check_cmd(draw_cmd_t seen);
        draw_cmd_t want;
        if (expected_cmds.size() == 0)
        begin
            $display({"%0t: unexpected command, expected none, ",
                      "actual op %0d x %0d y %0d glyph %0d last %0d"},
                     $time, seen.op, seen.pixel_x, seen.pixel_y, seen.glyph, seen.last);
            mismatches++;
            return;
        end
        want = expected_cmds.pop_front();
        compare_field("op", want.op, seen.op);
        compare_field("pixel_x", want.pixel_x, seen.pixel_x);
        compare_field("pixel_y", want.pixel_y, seen.pixel_y);
        compare_field("glyph", want.glyph, seen.glyph);
        compare_field("last", want.last, seen.last);
    endfunction
endclass

module text_console_cursor_engine_tb;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              kind;
    logic [7:0]        ch;
    logic              first_of_write;
    logic              last_of_write;
    logic              out_valid;
    logic              out_ready;
    logic              op;
    logic [PX_W-1:0]   pixel_x;
    logic [PY_W-1:0]   pixel_y;
    logic [7:0]        glyph;
    logic              last;

    console_cmd_board  board;
    draw_cmd_t         seen_cmd;
    int                tx_gap_pct;
    int                rx_stall_pct;
    logic              hold_pending;

    text_console_cursor_engine u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .ch             (ch),
        .first_of_write (first_of_write),
        .last_of_write  (last_of_write),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .op             (op),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .glyph          (glyph),
        .last           (last)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // The receiver stalls at random, or holds off for a long stretch on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left = 60;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_cmd.op      = op;
            seen_cmd.pixel_x = pixel_x;
            seen_cmd.pixel_y = pixel_y;
            seen_cmd.glyph   = glyph;
            seen_cmd.last    = last;
            board.check_cmd(seen_cmd);
        end
    end

    task automatic send_request(input logic k, input logic [7:0] c, input logic f,
                                input logic l);
        @(negedge clk);
        while ($urandom_range(99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        ch             <= c;
        first_of_write <= f;
        last_of_write  <= l;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        board.note_request(k, c, f, l);
    endtask

    task automatic wait_idle();
        int guard;
        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (board.expected_cmds.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return CH_LF;
        if (r < 14) return CH_CR;
        if (r < 26) return CH_BS;
        if (r < 30) return CH_FF;
        if (r < 45) return 8'($urandom);
        return 8'($urandom_range(33, 126));
    endfunction

    // Mostly well-formed write bursts, with ticks and stray characters mixed in.
    task automatic run_random(input int budget);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                send_request(KIND_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
            else if (pick < 22)
            begin
                send_request(KIND_CHAR, 8'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    send_request(KIND_CHAR, pick_char(), i == 0, i == len - 1);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_COLUMNS;
        cfg_data       = '0;
        in_valid       = 1'b0;
        kind           = KIND_CHAR;
        ch             = 8'h00;
        first_of_write = 1'b0;
        last_of_write  = 1'b0;
        tx_gap_pct     = 12;
        rx_stall_pct   = 60;
        hold_pending   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(KIND_CHAR, 8'h41, 1'b1, 1'b1);
        send_request(KIND_TICK, 8'h00, 1'b0, 1'b0);
        send_request(KIND_TICK, 8'hFF, 1'b1, 1'b1);
        send_request(KIND_CHAR, 8'h00, 1'b1, 1'b0);
        send_request(KIND_CHAR, 8'hFF, 1'b0, 1'b0);
        send_request(KIND_CHAR, CH_CR, 1'b0, 1'b0);
        send_request(KIND_CHAR, CH_LF, 1'b0, 1'b1);
        send_request(KIND_CHAR, CH_BS, 1'b1, 1'b0);
        send_request(KIND_CHAR, CH_FF, 1'b0, 1'b1);
        send_request(KIND_CHAR, CH_BS, 1'b1, 1'b1);
        wait_idle();

        write_reg(CFG_COLUMNS, 10'd1);
        write_reg(CFG_ROWS, 10'd1);
        send_request(KIND_CHAR, 8'h7E, 1'b1, 1'b1);
        send_request(KIND_CHAR, CH_BS, 1'b0, 1'b1);
        wait_idle();

        write_reg(CFG_COLUMNS, 10'd0);
        write_reg(CFG_ROWS, 10'd0);
        send_request(KIND_CHAR, 8'h5A, 1'b1, 1'b1);
        send_request(KIND_CHAR, CH_LF, 1'b0, 1'b0);
        wait_idle();

        // Walk the cursor to the far column of the largest screen and then down many rows.
        write_reg(CFG_COLUMNS, 10'h3FF);
        write_reg(CFG_ROWS, 10'h1FF);
        send_request(KIND_CHAR, CH_LF, 1'b0, 1'b0);
        send_request(KIND_CHAR, CH_BS, 1'b0, 1'b1);
        send_request(KIND_CHAR, 8'h80, 1'b0, 1'b1);
        for (int i = 0; i < 60; i++)
        begin
            send_request(KIND_CHAR, CH_LF, 1'b0, 1'b0);
        end
        send_request(KIND_CHAR, 8'h41, 1'b1, 1'b1);
        wait_idle();

        write_reg(CFG_COLUMNS, 10'd5);
        write_reg(CFG_ROWS, 10'd10);
        send_request(KIND_TICK, 8'h55, 1'b0, 1'b1);
        send_request(KIND_CHAR, 8'h42, 1'b1, 1'b1);
        wait_idle();

        write_reg(CFG_COLUMNS, 10'd7);
        write_reg(CFG_ROWS, 10'd4);
        hold_pending = 1'b1;
        run_random(40);
        wait_idle();

        tx_gap_pct   = 60;
        rx_stall_pct = 12;
        write_reg(CFG_COLUMNS, 10'd600);
        write_reg(CFG_ROWS, 10'd2);
        hold_pending = 1'b1;
        run_random(40);
        wait_idle();

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        write_reg(CFG_COLUMNS, 10'd3);
        write_reg(CFG_ROWS, 10'd300);
        hold_pending = 1'b1;
        run_random(40);
        wait_idle();

        if (board.expected_cmds.size() != 0)
        begin
            $display("%0t: %0d expected commands never arrived",
                     $time, board.expected_cmds.size());
            board.mismatches++;
        end
        if (board.mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
